// ===== rtl/crp_pkg.sv =====
package crp_pkg;

  localparam int unsigned ChWidth     = 8;
  localparam int unsigned RowWidth    = 20;
  localparam int unsigned ColWidth    = 14;
  localparam int unsigned RowAccWidth = 21;
  localparam int unsigned ColAccWidth = 15;

  localparam int unsigned RowCountDefault = 1048576;
  localparam int unsigned ColCountDefault = 16384;

  localparam logic [ChWidth-1:0] ChUpperA = 8'h41;
  localparam logic [ChWidth-1:0] ChUpperZ = 8'h5A;
  localparam logic [ChWidth-1:0] ChZero   = 8'h30;
  localparam logic [ChWidth-1:0] ChNine   = 8'h39;

  localparam int unsigned ColBase = 26;
  localparam int unsigned RowBase = 10;

  typedef enum logic [2:0] {
    PH_LETTERS = 3'b001,
    PH_DIGITS  = 3'b010,
    PH_ERROR   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ChWidth-1:0] ch;
    logic               last;
  } item_t;

  typedef struct packed {
    logic                ok;
    logic [RowWidth-1:0] row;
    logic [ColWidth-1:0] col;
  } result_t;

endpackage

// ===== rtl/crp_if.sv =====
interface crp_item_if
  import crp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ChWidth-1:0] ch;
  logic               last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface crp_result_if
  import crp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [RowWidth-1:0] row;
  logic [ColWidth-1:0] col;

  modport source (output valid, output ok, output row, output col, input ready);
  modport sink (input valid, input ok, input row, input col, output ready);
endinterface

// ===== rtl/cell_reference_parser.sv =====
// Cell reference parser (A1 style, e.g. "B12").
// Input channel item_i: one character per transaction (ch), with last set on
// the final character of a reference. Output channel result_o: one
// transaction per reference, carrying ok and the zero-based row and col;
// row and col are 0 when ok is 0.
// The format is one or more letters A..Z followed by one or more digits;
// the column is bijective base 26, the row decimal with leading zeros.
// Throughput: one character per cycle, sustained, except while a character
// with last waits for a stalled result register.
// An accepted character sits in the input register and is parsed as it
// advances; if it carries last, its result goes into the result register.
// Reset clears the parse state to the start of a reference and empties both
// registers. When the receiver stalls, the result register holds; characters
// without last keep flowing, and a character with last waits in the input
// register, stalling item_i, until the result register frees.
module cell_reference_parser
  import crp_pkg::*;
#(
  parameter int unsigned RowCount = RowCountDefault,
  parameter int unsigned ColCount = ColCountDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  crp_item_if.sink     item_i,
  crp_result_if.source result_o
);

  item_t   item_in, item_q;
  logic    item_valid, fire, out_free, has_result;
  result_t step_result, out_result;

  assign item_in.ch   = item_i.ch;
  assign item_in.last = item_i.last;

  assign fire = item_valid && (!item_q.last || out_free);

  crp_input_reg u_input_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (item_i.valid),
    .item_i   (item_in),
    .ready_o  (item_i.ready),
    .advance_i(fire),
    .valid_o  (item_valid),
    .item_o   (item_q)
  );

  crp_step #(
    .RowCount(RowCount),
    .ColCount(ColCount)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item_q),
    .has_result_o(has_result),
    .result_o    (step_result)
  );

  crp_output_reg u_output_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (has_result),
    .result_i(step_result),
    .free_o  (out_free),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .result_o(out_result)
  );

  assign result_o.ok  = out_result.ok;
  assign result_o.row = out_result.row;
  assign result_o.col = out_result.col;

endmodule

// ===== rtl/crp_input_reg.sv =====
module crp_input_reg
  import crp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/crp_step.sv =====
module crp_step
  import crp_pkg::*;
#(
  parameter int unsigned RowCount = RowCountDefault,
  parameter int unsigned ColCount = ColCountDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output logic    has_result_o,
  output result_t result_o
);

  localparam int unsigned ColProdWidth = ColAccWidth + 5;
  localparam int unsigned RowProdWidth = RowAccWidth + 4;
  localparam logic [ColAccWidth-1:0] ColMax = ColAccWidth'(ColCount);
  localparam logic [ColAccWidth-1:0] ColCap = ColAccWidth'(ColCount + 1);
  localparam logic [RowAccWidth-1:0] RowMax = RowAccWidth'(RowCount);
  localparam logic [RowAccWidth-1:0] RowCap = RowAccWidth'(RowCount + 1);

  phase_e                 phase_q, phase_d, phase_n;
  logic [ColAccWidth-1:0] col_q, col_d, col_n, col_mac;
  logic [RowAccWidth-1:0] row_q, row_d, row_n, row_mac;
  logic                   seen_q, seen_d, seen_n;
  logic                   is_letter, is_digit, ok;
  logic [ColProdWidth-1:0] col_wide;
  logic [RowProdWidth-1:0] row_wide;
  logic [4:0]             letter_val;
  logic [3:0]             digit_val;

  assign is_letter  = (item_i.ch >= ChUpperA) && (item_i.ch <= ChUpperZ);
  assign is_digit   = (item_i.ch >= ChZero) && (item_i.ch <= ChNine);
  assign letter_val = 5'(item_i.ch - ChUpperA + 8'd1);
  assign digit_val  = 4'(item_i.ch - ChZero);

  assign col_wide = ColProdWidth'(col_q) * ColProdWidth'(ColBase)
                  + ColProdWidth'(letter_val);
  assign row_wide = RowProdWidth'(row_q) * RowProdWidth'(RowBase)
                  + RowProdWidth'(digit_val);
  assign col_mac  = (col_wide > ColProdWidth'(ColCap)) ? ColCap : col_wide[ColAccWidth-1:0];
  assign row_mac  = (row_wide > RowProdWidth'(RowCap)) ? RowCap : row_wide[RowAccWidth-1:0];

  always_comb begin
    phase_n = phase_q;
    col_n   = col_q;
    row_n   = row_q;
    seen_n  = seen_q;
    case (phase_q)
      PH_LETTERS: begin
        if (is_letter) begin
          col_n = col_mac;
        end else if (is_digit && (col_q != '0)) begin
          phase_n = PH_DIGITS;
          row_n   = row_mac;
          seen_n  = 1'b1;
        end else begin
          phase_n = PH_ERROR;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          row_n  = row_mac;
          seen_n = 1'b1;
        end else begin
          phase_n = PH_ERROR;
        end
      end
      default: begin
        phase_n = PH_ERROR;
      end
    endcase
  end

  assign ok = (phase_n == PH_DIGITS) && seen_n
           && (row_n != '0) && (row_n <= RowMax)
           && (col_n != '0) && (col_n <= ColMax);

  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    seen_d  = seen_q;
    if (fire_i) begin
      if (item_i.last) begin
        phase_d = PH_LETTERS;
        col_d   = '0;
        row_d   = '0;
        seen_d  = 1'b0;
      end else begin
        phase_d = phase_n;
        col_d   = col_n;
        row_d   = row_n;
        seen_d  = seen_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LETTERS;
      col_q   <= '0;
      row_q   <= '0;
      seen_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      seen_q  <= seen_d;
    end
  end

  assign has_result_o = fire_i && item_i.last;
  assign result_o.ok  = ok;
  assign result_o.row = ok ? RowWidth'(row_n - 21'd1) : '0;
  assign result_o.col = ok ? ColWidth'(col_n - 15'd1) : '0;

endmodule

// ===== rtl/crp_output_reg.sv =====
module crp_output_reg
  import crp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== bench/tb_cell_reference_parser.sv =====
`timescale 1ns / 100ps

module tb_cell_reference_parser;
  import crp_pkg::*;

  localparam int unsigned RowLimit   = RowCountDefault;
  localparam int unsigned ColLimit   = ColCountDefault;
  localparam int unsigned ItemTarget = 1700;
  localparam int unsigned CalmItems  = 150;
  localparam int unsigned QuietLimit = 2000;

  typedef struct packed {
    logic [ChWidth-1:0] ch;
    logic               fin;
    logic               typed;
    result_t            want;
  } dir_row_t;

  localparam result_t Rejected = '{ok: 1'b0, row: '0, col: '0};
  localparam result_t FirstCell = '{ok: 1'b1, row: '0, col: '0};
  localparam result_t LastCell = '{ok: 1'b1, row: 20'd1048575, col: 14'd16383};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crp_item_if   item_bus ();
  crp_result_if result_bus ();

  cell_reference_parser #(
    .RowCount(RowLimit),
    .ColCount(ColLimit)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  always #10 clk = ~clk;

  phase_e                 parse_phase = PH_LETTERS;
  logic [ColAccWidth-1:0] col_acc = '0;
  logic [RowAccWidth-1:0] row_acc = '0;
  logic                   digit_seen = 1'b0;

  result_t     pending_results[$];
  result_t     oldest;
  logic [7:0]  text_q[$];
  int unsigned items_sent = 0;
  int unsigned reference_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;

  dir_row_t directed_rows [27] = '{
    '{"A", 1'b0, 1'b0, Rejected}, '{"1", 1'b1, 1'b1, FirstCell},
    '{"0", 1'b1, 1'b1, Rejected},
    '{8'h00, 1'b1, 1'b1, Rejected},
    '{"A", 1'b0, 1'b0, Rejected}, '{"0", 1'b1, 1'b1, Rejected},
    '{"B", 1'b1, 1'b1, Rejected},
    '{"X", 1'b0, 1'b0, Rejected}, '{"F", 1'b0, 1'b0, Rejected},
    '{"D", 1'b0, 1'b0, Rejected}, '{"1", 1'b0, 1'b0, Rejected},
    '{"0", 1'b0, 1'b0, Rejected}, '{"4", 1'b0, 1'b0, Rejected},
    '{"8", 1'b0, 1'b0, Rejected}, '{"5", 1'b0, 1'b0, Rejected},
    '{"7", 1'b0, 1'b0, Rejected}, '{"6", 1'b1, 1'b1, LastCell},
    '{"X", 1'b0, 1'b0, Rejected}, '{"F", 1'b0, 1'b0, Rejected},
    '{"E", 1'b0, 1'b0, Rejected}, '{"1", 1'b1, 1'b1, Rejected},
    '{"A", 1'b0, 1'b0, Rejected}, '{"1", 1'b0, 1'b0, Rejected},
    '{"B", 1'b1, 1'b1, Rejected},
    '{"A", 1'b0, 1'b0, Rejected}, '{8'hFF, 1'b0, 1'b0, Rejected},
    '{"1", 1'b1, 1'b1, Rejected}
  };

  function automatic int unsigned grow_saturated(int unsigned acc, int unsigned base,
                                                 int unsigned add, int unsigned cap);
    longint unsigned v;
    v = longint'(acc) * base + add;
    return (v > cap) ? cap : 32'(v);
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic fin, output result_t res);
    bit is_letter;
    bit is_digit;
    bit good;
    is_letter = (c >= ChUpperA) && (c <= ChUpperZ);
    is_digit  = (c >= ChZero) && (c <= ChNine);
    res = '0;
    case (parse_phase)
      PH_LETTERS: begin
        if (is_letter) begin
          col_acc = ColAccWidth'(grow_saturated(col_acc, ColBase,
                                                int'(c) - int'(ChUpperA) + 1, ColLimit + 1));
        end else if (is_digit && col_acc != 0) begin
          parse_phase = PH_DIGITS;
          row_acc = RowAccWidth'(grow_saturated(row_acc, RowBase,
                                                int'(c) - int'(ChZero), RowLimit + 1));
          digit_seen = 1'b1;
        end else begin
          parse_phase = PH_ERROR;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          row_acc = RowAccWidth'(grow_saturated(row_acc, RowBase,
                                                int'(c) - int'(ChZero), RowLimit + 1));
          digit_seen = 1'b1;
        end else begin
          parse_phase = PH_ERROR;
        end
      end
      default: parse_phase = PH_ERROR;
    endcase
    if (!fin) return 1'b0;
    good = (parse_phase == PH_DIGITS) && digit_seen &&
           (row_acc >= 1) && (row_acc <= RowLimit) &&
           (col_acc >= 1) && (col_acc <= ColLimit);
    if (good) begin
      res.ok  = 1'b1;
      res.row = RowWidth'(row_acc - 1);
      res.col = ColWidth'(col_acc - 1);
    end
    parse_phase = PH_LETTERS;
    col_acc     = '0;
    row_acc     = '0;
    digit_seen  = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                           input result_t want);
    result_t got;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.ch    <= c;
    item_bus.last  <= fin;
    do @(posedge clk); while (!item_bus.ready);
    if (parse_char(c, fin, got)) pending_results.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic int unsigned pick_column();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(1, 26);
      2, 3:    return $urandom_range(27, 702);
      7:       return $urandom_range(ColLimit - 3, ColLimit + 3);
      8:       return $urandom_range(ColLimit + 1, 500000);
      default: return $urandom_range(1, ColLimit);
    endcase
  endfunction

  function automatic int unsigned pick_row();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(1, 999);
      6:          return $urandom_range(RowLimit - 3, RowLimit + 3);
      7:          return 0;
      8:          return $urandom_range(RowLimit + 1, 32'hFFFF_FFFF);
      9:          return $urandom_range(1, 99);
      default:    return $urandom_range(1, RowLimit);
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h61, 8'h7A));
      1:       return 8'($urandom_range(8'h21, 8'h2F));
      2:       return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic append_column(input int unsigned n);
    int unsigned base;
    base = text_q.size();
    while (n > 0) begin
      n--;
      text_q.insert(base, 8'(int'(ChUpperA) + n % ColBase));
      n = n / ColBase;
    end
  endtask

  task automatic append_row(input int unsigned n);
    int unsigned base;
    base = text_q.size();
    do begin
      text_q.insert(base, 8'(int'(ChZero) + n % RowBase));
      n = n / RowBase;
    end while (n != 0);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.insert(base, ChZero);
    end
  endtask

  task automatic compose_reference();
    int unsigned kind;
    int unsigned pos;
    kind = $urandom_range(0, 99);
    text_q.delete();
    if (kind < 72) begin
      append_column(pick_column());
      append_row(pick_row());
      if (kind >= 60) begin
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = noise_byte();
      end
    end else if (kind < 78) begin
      append_column(pick_column());
    end else if (kind < 84) begin
      append_row(pick_row());
    end else if (kind < 88) begin
      append_column(pick_column());
      append_row(pick_row());
      append_column($urandom_range(1, 702));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) != 0) begin
          text_q.push_back(($urandom_range(0, 1) != 0) ?
                           8'($urandom_range(ChUpperA, ChUpperZ)) :
                           8'($urandom_range(ChZero, ChNine)));
        end else begin
          text_q.push_back(noise_byte());
        end
      end
    end
  endtask

  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 7) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: ok=%0d row=%0d col=%0d",
               result_bus.ok, result_bus.row, result_bus.col);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (result_bus.ok !== oldest.ok) begin
          $error("ok: expected %0d, actual %0d", oldest.ok, result_bus.ok);
          mismatch_count++;
        end
        if (result_bus.row !== oldest.row) begin
          $error("row: expected %0d, actual %0d", oldest.row, result_bus.row);
          mismatch_count++;
        end
        if (result_bus.col !== oldest.col) begin
          $error("col: expected %0d, actual %0d", oldest.col, result_bus.col);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_cell_reference_parser NOT OK");
      $finish;
    end
  end

  initial begin
    item_bus.valid <= 1'b0;
    item_bus.ch    <= '0;
    item_bus.last  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].ch, directed_rows[i].fin, directed_rows[i].typed,
                directed_rows[i].want);
    end
    hold_until_drained();
    while (items_sent < ItemTarget) begin
      idle_en = !(items_sent >= 700 && items_sent < 900) &&
                (items_sent < ItemTarget - CalmItems);
      if (reference_count % 250 == 249) hold_until_drained();
      compose_reference();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1, 1'b0, Rejected);
      reference_count++;
    end
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_cell_reference_parser OK");
    end else begin
      $display("tb_cell_reference_parser NOT OK");
    end
    $finish;
  end

endmodule
